// ----- hdl/signed_int_to_decimal_ascii_unit_assert.svh -----
// assertion macros for the signed integer to decimal text unit
// needs a clk in the scope of each use, and an rst_n for SITDA_ASSERT
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// checked only outside reset
`define SITDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define SITDA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/sitda_pkg.sv -----
// shared widths, character codes and types for the decimal text unit
// no dependencies
package sitda_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 4;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [CHAR_W-1:0]         char_t;
    typedef logic [LEN_W-1:0]          len_t;
    typedef logic [DIGIT_W-1:0]        digit_t;
    typedef logic [BCD_W-1:0]          bcd_t;

endpackage

// ----- hdl/sitda_in_if.sv -----
// input channel of the decimal text unit: one signed integer per item
// uses sitda_pkg
interface sitda_in_if;
    logic             valid;
    logic             ready;
    sitda_pkg::value_t value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ----- hdl/sitda_out_if.sv -----
// output channel of the decimal text unit: one character per item
// uses sitda_pkg
interface sitda_out_if;
    logic             valid;
    logic             ready;
    sitda_pkg::char_t ascii_char;
    sitda_pkg::len_t  total_length;
    logic             last_char;

    modport source (output valid, output ascii_char, output total_length,
                    output last_char, input ready);
    modport sink   (input valid, input ascii_char, input total_length,
                    input last_char, output ready);
endinterface

// ----- hdl/signed_int_to_decimal_ascii_unit.sv -----
// signed 32-bit integer to decimal ascii text, one character per output item
// uses sitda_pkg, sitda_in_if, sitda_out_if and the assertion macro header
//
//  channel  dir  payload                                 per item
//  number   in   value (32, signed)                      one integer
//  text     out  ascii_char (8), total_length (4),       one character,
//                last_char (1)                           1 to 11 per integer
//
// an integer is taken only when the unit is idle, so a new integer waits until
// the last character of the previous one has been taken; the conversion runs
// the bit-serial shift-add-3 binary to bcd loop over all 32 magnitude bits,
// then strips leading zero digits, then hands out the characters.
// rst_n clears the sequencer at once; no memory to clear
// a stall on text holds the current character and freezes the sequencer
`include "signed_int_to_decimal_ascii_unit_assert.svh"

module signed_int_to_decimal_ascii_unit (
    input  logic        clk,
    input  logic        rst_n,
    sitda_in_if.sink    number,
    sitda_out_if.source text
);

    // sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for an integer
    localparam logic [1:0] ST_CONV = 2'd1;  // one magnitude bit per cycle into bcd
    localparam logic [1:0] ST_SKIP = 2'd2;  // drop leading zero digits
    localparam logic [1:0] ST_EMIT = 2'd3;  // hand out characters

    localparam logic [4:0] LAST_BIT = 5'd31;
    localparam logic [3:0] ALL_DIGITS = 4'(sitda_pkg::NUM_DIGITS);
    localparam logic [3:0] ONE_DIGIT  = 4'd1;

    logic [1:0]                          state_reg,     state_next;
    logic [sitda_pkg::VALUE_W-1:0]       mag_reg,       mag_next;
    sitda_pkg::bcd_t                     bcd_reg,       bcd_next;
    logic [4:0]                          bit_cnt_reg,   bit_cnt_next;
    logic [3:0]                          dig_cnt_reg,   dig_cnt_next;
    logic                                neg_reg,       neg_next;
    logic                                sign_pend_reg, sign_pend_next;
    sitda_pkg::len_t                     len_reg,       len_next;

    sitda_pkg::bcd_t                     bcd_adj;
    sitda_pkg::digit_t                   top_digit;
    logic [sitda_pkg::VALUE_W-1:0]       in_bits;
    logic                                in_fire;
    logic                                out_fire;

    // helpers for the checks
    logic                                is_minus;
    logic                                char_ok;
    logic                                minus_ok;

    assign in_bits   = sitda_pkg::VALUE_W'(number.value);
    assign in_fire   = number.valid && number.ready;
    assign out_fire  = text.valid && text.ready;
    assign top_digit = bcd_reg[sitda_pkg::BCD_W-1 -: sitda_pkg::DIGIT_W];

    // shift-add-3 correction, each digit on its own
    always_comb
    begin
        for (int d = 0; d < sitda_pkg::NUM_DIGITS; d++)
        begin
            if (bcd_reg[d*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] > 4'd4)
            begin
                bcd_adj[d*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] =
                    bcd_reg[d*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] + 4'd3;
            end
            else
            begin
                bcd_adj[d*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] =
                    bcd_reg[d*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W];
            end
        end
    end

    // port side: all from registers
    assign number.ready      = (state_reg == ST_IDLE);
    assign text.valid        = (state_reg == ST_EMIT);
    assign text.ascii_char   = sign_pend_reg ? sitda_pkg::ASCII_MINUS
                                             : sitda_pkg::ASCII_ZERO + {4'd0, top_digit};
    assign text.total_length = len_reg;
    assign text.last_char    = !sign_pend_reg && (dig_cnt_reg == ONE_DIGIT);

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        neg_next       = neg_reg;
        sign_pend_next = sign_pend_reg;
        len_next       = len_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    // magnitude as unsigned, so the most negative value works too
                    neg_next     = in_bits[sitda_pkg::VALUE_W-1];
                    mag_next     = in_bits[sitda_pkg::VALUE_W-1]
                                 ? (~in_bits + sitda_pkg::VALUE_W'(1)) : in_bits;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[sitda_pkg::BCD_W-2:0], mag_reg[sitda_pkg::VALUE_W-1]};
                mag_next     = {mag_reg[sitda_pkg::VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == LAST_BIT)
                begin
                    dig_cnt_next = ALL_DIGITS;
                    state_next   = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // zero keeps its single digit
                if ((top_digit == '0) && (dig_cnt_reg != ONE_DIGIT))
                begin
                    bcd_next     = {bcd_reg[sitda_pkg::BCD_W-sitda_pkg::DIGIT_W-1:0],
                                    sitda_pkg::DIGIT_W'(0)};
                    dig_cnt_next = dig_cnt_reg - 4'd1;
                end
                else
                begin
                    len_next       = dig_cnt_reg + {3'd0, neg_reg};
                    sign_pend_next = neg_reg;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    if (sign_pend_reg)
                    begin
                        sign_pend_next = 1'b0;
                    end
                    else if (dig_cnt_reg == ONE_DIGIT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        bcd_next     = {bcd_reg[sitda_pkg::BCD_W-sitda_pkg::DIGIT_W-1:0],
                                        sitda_pkg::DIGIT_W'(0)};
                        dig_cnt_next = dig_cnt_reg - 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sign_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sign_pend_reg <= sign_pend_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        neg_reg     <= neg_next;
        len_reg     <= len_next;
    end

    // checks
    assign is_minus = (text.ascii_char == sitda_pkg::ASCII_MINUS);
    assign char_ok  = is_minus || ((text.ascii_char >= sitda_pkg::ASCII_ZERO)
                                   && (text.ascii_char <= sitda_pkg::ASCII_NINE));
    assign minus_ok = (text.total_length >= 4'd2) && !text.last_char;

    `SITDA_ASSERT_ALWAYS(a_no_overlap, !(number.ready && text.valid), "ready while emitting")
    `SITDA_ASSERT(a_conv_time, in_fire |-> ##33 (state_reg == ST_SKIP), "bad conversion time")
    `SITDA_ASSERT(a_last_idle, (out_fire && text.last_char) |=> number.ready, "not idle at end")
    `SITDA_ASSERT(a_char_range, text.valid |-> char_ok, "character out of range")
    `SITDA_ASSERT(a_minus_len, (text.valid && is_minus) |-> minus_ok, "bad minus item")

endmodule
